>>> design/sombmc_pkg.sv
// Shared constants, types and codes of the SOM best-match classifier.
// No dependencies; every other file of the block but sombmc_ram uses this package.
`timescale 1ns / 1ps
`default_nettype none

package sombmc_pkg;

   // Map geometry.
   localparam int MAP_ROWS   = 15;
   localparam int MAP_COLS   = 15;
   localparam int VECTOR_LEN = 4;

   localparam int NODE_COUNT = MAP_ROWS * MAP_COLS;
   localparam int ELEM_COUNT = NODE_COUNT * VECTOR_LEN;

   localparam int ROW_W   = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
   localparam int COL_W   = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
   localparam int RC_W    = (ROW_W > COL_W) ? ROW_W : COL_W;
   localparam int GRID_W  = 2 * RC_W + 1;
   localparam int NODE_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int WADDR_W = (ELEM_COUNT > 1) ? $clog2(ELEM_COUNT) : 1;

   // Data widths fixed by the word format.
   localparam int WEIGHT_W = 16;
   localparam int LABEL_W  = 8;
   localparam int DIST_W   = 36;
   localparam int PROD_W   = 33;

   localparam logic [DIST_W-1:0]  LIMIT_RESET = 36'd655360000;
   localparam logic [1:0]         ELEM_LAST   = 2'(VECTOR_LEN - 1);
   localparam logic [ROW_W-1:0]   ROW_LAST    = ROW_W'(MAP_ROWS - 1);
   localparam logic [COL_W-1:0]   COL_LAST    = COL_W'(MAP_COLS - 1);
   localparam logic [WADDR_W-1:0] WADDR_LAST  = WADDR_W'(ELEM_COUNT - 1);
   localparam logic [WADDR_W-1:0] NADDR_LAST  = WADDR_W'(NODE_COUNT - 1);

   // Request codes.
   typedef enum logic [1:0] {
      REQ_LOAD_WEIGHT = 2'd0,
      REQ_LOAD_LABEL  = 2'd1,
      REQ_QUERY       = 2'd2
   } req_kind_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WSCAN = 4'b0010,
      ST_LSCAN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // Tag that travels with one weight read through the distance unit.
   typedef struct packed {
      logic             valid;
      logic             last_node;
      logic [1:0]       elem;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } tag_type;

   // Finished squared distance of one node.
   typedef struct packed {
      logic              valid;
      logic              last_node;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [DIST_W-1:0] distance;
   } node_dist_type;

   // Tag that travels with one label read.
   typedef struct packed {
      logic              valid;
      logic              last_node;
      logic [GRID_W-1:0] grid;
   } ltag_type;

endpackage

`default_nettype wire

>>> design/sombmc_if.sv
// Valid/ready channel interfaces of the SOM best-match classifier.
// Depends on sombmc_pkg for the csr data width.
`timescale 1ns / 1ps
`default_nettype none

interface sombmc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [3:0]  node_row;
   logic [3:0]  node_col;
   logic [1:0]  elem_index;
   logic signed [15:0] weight_value;
   logic [7:0]  label_value;
   logic signed [15:0] query_0;
   logic signed [15:0] query_1;
   logic signed [15:0] query_2;
   logic signed [15:0] query_3;

   modport source (output valid, req_type, node_row, node_col, elem_index, weight_value,
                   label_value, query_0, query_1, query_2, query_3, input ready);
   modport sink (input valid, req_type, node_row, node_col, elem_index, weight_value,
                 label_value, query_0, query_1, query_2, query_3, output ready);
endinterface

interface sombmc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] class_label;
   logic [3:0] winner_row;
   logic [3:0] winner_col;

   modport source (output valid, class_label, winner_row, winner_col, input ready);
   modport sink (input valid, class_label, winner_row, winner_col, output ready);
endinterface

interface sombmc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [sombmc_pkg::DIST_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> design/sombmc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sombmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                             wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> design/sombmc_dist_unit.sv
// Shared square-and-accumulate unit: one weight element per cycle, one
// node distance every VECTOR_LEN elements. Depends on sombmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sombmc_dist_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire sombmc_pkg::tag_type          tag,
   input  wire logic signed [15:0]           q_elem,
   input  wire logic [15:0]                  w_elem,
   output sombmc_pkg::node_dist_type         node
);

   logic signed [16:0] diff;
   logic signed [33:0] square;

   sombmc_pkg::tag_type                   tag_a_ff;
   logic [sombmc_pkg::PROD_W-1:0]         prod_ff;
   logic [sombmc_pkg::DIST_W-1:0]         acc_ff, acc_in;
   logic [sombmc_pkg::DIST_W-1:0]         sum;
   sombmc_pkg::node_dist_type             node_ff, node_in;

   // Stage A: difference and square.
   assign diff   = {q_elem[15], q_elem} - {w_elem[15], $signed(w_elem)};
   assign square = diff * diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff.valid <= 1'b0;
      end else begin
         tag_a_ff.valid <= tag.valid;
      end
      tag_a_ff.last_node <= tag.last_node;
      tag_a_ff.elem      <= tag.elem;
      tag_a_ff.row       <= tag.row;
      tag_a_ff.col       <= tag.col;
      prod_ff            <= square[sombmc_pkg::PROD_W-1:0];
   end

   // Stage B: accumulate; the sum closes on the last element of a node.
   assign sum = acc_ff + sombmc_pkg::DIST_W'(prod_ff);

   always_comb begin
      acc_in            = acc_ff;
      node_in.valid     = 1'b0;
      node_in.last_node = tag_a_ff.last_node;
      node_in.row       = tag_a_ff.row;
      node_in.col       = tag_a_ff.col;
      node_in.distance  = sum;
      if (tag_a_ff.valid) begin
         if (tag_a_ff.elem == sombmc_pkg::ELEM_LAST) begin
            acc_in        = '0;
            node_in.valid = 1'b1;
         end else begin
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         node_ff.valid <= 1'b0;
      end else begin
         acc_ff        <= acc_in;
         node_ff.valid <= node_in.valid;
      end
      node_ff.last_node <= node_in.last_node;
      node_ff.row       <= node_in.row;
      node_ff.col       <= node_in.col;
      node_ff.distance  <= node_in.distance;
   end

   assign node = node_ff;

endmodule

`default_nettype wire

>>> design/som_best_match_classifier_top.sv
// Top level of the SOM best-match classifier: sequencer, stores, scans.
// Depends on sombmc_pkg, sombmc_if, sombmc_ram and sombmc_dist_unit.
`timescale 1ns / 1ps
`default_nettype none

// How to use this block:
// Words enter on the req channel. A load-weight word writes one Q8.8 weight
// of one map node, a load-label word writes the class label of one node, and
// a query word brings a four-element vector. Loads outside the map and words
// of the unused request code are dropped without a response.
// Loads are written into the stores as they are accepted. A query makes two
// passes: the first pass streams every weight through the single read port
// of the weight RAM and the shared square-and-accumulate unit, one element
// per cycle, to find the winning node; the second pass reads every label,
// one per cycle, to find the labelled node nearest the winner on the grid.
// req_ready is low during the whole query.
// Each query gives one word on the rsp channel: the label and the winner's
// row and column. The response sits in an output register; if the receiver
// stalls, the block can still take loads, but a finished query waits until
// the previous response has been taken.
// The csr channel writes the distance limit and is always ready; write it only
// while the block is idle. Reset (synchronous) sets the limit to 10000.0,
// clears the remembered label and empties the output register. The weight and
// label stores have no reset and must be loaded before they are queried.
module som_best_match_classifier_top (
   input  wire logic         clock,
   input  wire logic         reset,
   sombmc_req_if.sink        req_port,
   sombmc_rsp_if.source      rsp_port,
   sombmc_csr_if.sink        csr_port
);

   localparam int ROW_W   = sombmc_pkg::ROW_W;
   localparam int COL_W   = sombmc_pkg::COL_W;
   localparam int RC_W    = sombmc_pkg::RC_W;
   localparam int GRID_W  = sombmc_pkg::GRID_W;
   localparam int NODE_W  = sombmc_pkg::NODE_W;
   localparam int WADDR_W = sombmc_pkg::WADDR_W;
   localparam int DIST_W  = sombmc_pkg::DIST_W;
   localparam int LABEL_W = sombmc_pkg::LABEL_W;

   sombmc_pkg::state_type state_ff, state_in;

   // Configuration and remembered label.
   logic [DIST_W-1:0]  limit_ff;
   logic [LABEL_W-1:0] last_label_ff, last_label_in;

   // Query vector.
   logic signed [15:0] q_ff [4];

   // Scan counters shared by both passes.
   logic               issue_ff, issue_in;
   logic [WADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic [1:0]         elem_ff, elem_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;

   // Winner search.
   logic [DIST_W-1:0]  best_ff, best_in;
   logic [ROW_W-1:0]   win_row_ff, win_row_in;
   logic [COL_W-1:0]   win_col_ff, win_col_in;

   // Label search.
   logic               found_ff, found_in;
   logic [GRID_W-1:0]  best_grid_ff, best_grid_in;
   logic [LABEL_W-1:0] label_ff, label_in;

   // Read pipeline tags.
   sombmc_pkg::tag_type       wtag_ff, wtag_in;
   sombmc_pkg::ltag_type      ltag_ff, ltag_in;
   sombmc_pkg::node_dist_type node;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LABEL_W-1:0] rsp_label_ff;
   logic [3:0]         rsp_row_ff, rsp_col_ff;
   logic               rsp_load;

   // Store ports.
   logic               req_accept;
   logic               w_we, l_we;
   logic [WADDR_W-1:0] w_waddr;
   logic [NODE_W-1:0]  l_waddr;
   logic [15:0]        w_rdata;
   logic [LABEL_W-1:0] l_rdata;
   logic               load_in_map;

   // Grid distance of the node being issued in the label pass.
   logic [RC_W-1:0]    dr, dc;
   logic [GRID_W-1:0]  grid;

   assign req_port.ready = (state_ff == sombmc_pkg::ST_IDLE);
   assign req_accept     = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;

   // Loads write the stores directly while the sequencer is idle.
   assign load_in_map = (int'(req_port.node_row) < sombmc_pkg::MAP_ROWS)
                     && (int'(req_port.node_col) < sombmc_pkg::MAP_COLS);

   assign w_waddr = WADDR_W'((int'(req_port.node_row) * sombmc_pkg::MAP_COLS
                             + int'(req_port.node_col)) * sombmc_pkg::VECTOR_LEN
                             + int'(req_port.elem_index));
   assign l_waddr = NODE_W'(int'(req_port.node_row) * sombmc_pkg::MAP_COLS
                            + int'(req_port.node_col));

   always_comb begin
      w_we = 1'b0;
      l_we = 1'b0;
      if (req_accept && load_in_map) begin
         unique case (req_port.req_type)
            sombmc_pkg::REQ_LOAD_WEIGHT: begin
               w_we = (int'(req_port.elem_index) < sombmc_pkg::VECTOR_LEN);
            end
            sombmc_pkg::REQ_LOAD_LABEL: begin
               l_we = 1'b1;
            end
            default: begin
               w_we = 1'b0;
               l_we = 1'b0;
            end
         endcase
      end
   end

   sombmc_ram #(
      .WIDTH (16),
      .DEPTH (sombmc_pkg::ELEM_COUNT)
   ) u_weight_ram (
      .clock (clock),
      .we    (w_we),
      .waddr (w_waddr),
      .wdata (req_port.weight_value),
      .raddr (scan_addr_ff),
      .rdata (w_rdata)
   );

   sombmc_ram #(
      .WIDTH (LABEL_W),
      .DEPTH (sombmc_pkg::NODE_COUNT)
   ) u_label_ram (
      .clock (clock),
      .we    (l_we),
      .waddr (l_waddr),
      .wdata (req_port.label_value),
      .raddr (scan_addr_ff[NODE_W-1:0]),
      .rdata (l_rdata)
   );

   sombmc_dist_unit u_dist (
      .clock  (clock),
      .reset  (reset),
      .tag    (wtag_ff),
      .q_elem (q_ff[wtag_ff.elem]),
      .w_elem (w_rdata),
      .node   (node)
   );

   // Squared grid distance from the counters to the winner.
   always_comb begin
      dr = (row_ff > win_row_ff) ? RC_W'(row_ff - win_row_ff) : RC_W'(win_row_ff - row_ff);
      dc = (col_ff > win_col_ff) ? RC_W'(col_ff - win_col_ff) : RC_W'(win_col_ff - col_ff);
      grid = GRID_W'(dr) * GRID_W'(dr) + GRID_W'(dc) * GRID_W'(dc);
   end

   assign rsp_load = (state_ff == sombmc_pkg::ST_DONE) && (!rsp_valid_ff || rsp_port.ready);

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      scan_addr_in  = scan_addr_ff;
      elem_in       = elem_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      best_in       = best_ff;
      win_row_in    = win_row_ff;
      win_col_in    = win_col_ff;
      found_in      = found_ff;
      best_grid_in  = best_grid_ff;
      label_in      = label_ff;
      last_label_in = last_label_ff;

      wtag_in.valid     = 1'b0;
      wtag_in.last_node = (scan_addr_ff == sombmc_pkg::WADDR_LAST);
      wtag_in.elem      = elem_ff;
      wtag_in.row       = row_ff;
      wtag_in.col       = col_ff;
      ltag_in.valid     = 1'b0;
      ltag_in.last_node = (scan_addr_ff == sombmc_pkg::NADDR_LAST);
      ltag_in.grid      = grid;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         sombmc_pkg::ST_IDLE: begin
            if (req_accept && (req_port.req_type == sombmc_pkg::REQ_QUERY)) begin
               state_in     = sombmc_pkg::ST_WSCAN;
               issue_in     = 1'b1;
               scan_addr_in = '0;
               elem_in      = '0;
               row_in       = '0;
               col_in       = '0;
               best_in      = limit_ff;
               win_row_in   = '0;
               win_col_in   = '0;
               found_in     = 1'b0;
               best_grid_in = '0;
               label_in     = last_label_ff;
            end
         end
         sombmc_pkg::ST_WSCAN: begin
            if (issue_ff) begin
               wtag_in.valid = 1'b1;
               scan_addr_in  = scan_addr_ff + 1'b1;
               if (scan_addr_ff == sombmc_pkg::WADDR_LAST) begin
                  issue_in = 1'b0;
               end
               if (elem_ff == sombmc_pkg::ELEM_LAST) begin
                  elem_in = '0;
                  if (col_ff == sombmc_pkg::COL_LAST) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end else begin
                  elem_in = elem_ff + 1'b1;
               end
            end
            // Strictly smaller wins, so the first node in row-major order
            // keeps a tie.
            if (node.valid) begin
               if (node.distance < best_ff) begin
                  best_in    = node.distance;
                  win_row_in = node.row;
                  win_col_in = node.col;
               end
               if (node.last_node) begin
                  state_in     = sombmc_pkg::ST_LSCAN;
                  issue_in     = 1'b1;
                  scan_addr_in = '0;
                  row_in       = '0;
                  col_in       = '0;
               end
            end
         end
         sombmc_pkg::ST_LSCAN: begin
            if (issue_ff) begin
               ltag_in.valid = 1'b1;
               scan_addr_in  = scan_addr_ff + 1'b1;
               if (scan_addr_ff == sombmc_pkg::NADDR_LAST) begin
                  issue_in = 1'b0;
               end
               if (col_ff == sombmc_pkg::COL_LAST) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
            if (ltag_ff.valid) begin
               if ((l_rdata != '0) && (!found_ff || (ltag_ff.grid < best_grid_ff))) begin
                  found_in     = 1'b1;
                  best_grid_in = ltag_ff.grid;
                  label_in     = l_rdata;
               end
               if (ltag_ff.last_node) begin
                  state_in = sombmc_pkg::ST_DONE;
               end
            end
         end
         sombmc_pkg::ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               last_label_in = label_ff;
               state_in      = sombmc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sombmc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sombmc_pkg::ST_IDLE;
         limit_ff      <= sombmc_pkg::LIMIT_RESET;
         last_label_ff <= '0;
         issue_ff      <= 1'b0;
         wtag_ff.valid <= 1'b0;
         ltag_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_label_ff <= last_label_in;
         issue_ff      <= issue_in;
         wtag_ff.valid <= wtag_in.valid;
         ltag_ff.valid <= ltag_in.valid;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_port.valid && csr_port.ready) begin
            limit_ff <= csr_port.data;
         end
      end
      wtag_ff.last_node <= wtag_in.last_node;
      wtag_ff.elem      <= wtag_in.elem;
      wtag_ff.row       <= wtag_in.row;
      wtag_ff.col       <= wtag_in.col;
      ltag_ff.last_node <= ltag_in.last_node;
      ltag_ff.grid      <= ltag_in.grid;
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_port.req_type == sombmc_pkg::REQ_QUERY)) begin
         q_ff[0] <= req_port.query_0;
         q_ff[1] <= req_port.query_1;
         q_ff[2] <= req_port.query_2;
         q_ff[3] <= req_port.query_3;
      end
      scan_addr_ff      <= scan_addr_in;
      elem_ff           <= elem_in;
      row_ff            <= row_in;
      col_ff            <= col_in;
      best_ff           <= best_in;
      win_row_ff        <= win_row_in;
      win_col_ff        <= win_col_in;
      found_ff          <= found_in;
      best_grid_ff      <= best_grid_in;
      label_ff          <= label_in;
      if (rsp_load) begin
         rsp_label_ff <= label_ff;
         rsp_row_ff   <= 4'(win_row_ff);
         rsp_col_ff   <= 4'(win_col_ff);
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.class_label = rsp_label_ff;
   assign rsp_port.winner_row  = rsp_row_ff;
   assign rsp_port.winner_col  = rsp_col_ff;

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for som_best_match_classifier_top: fills the map, runs queries under
// several distance limits, and checks every response against an in-bench prediction.
// Depends on sombmc_pkg and the channel interfaces in design/sombmc_if.sv.
`timescale 1ns / 1ps

module tb;

   // The fourth request code has no meaning; the block must drop such words.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 16;
   localparam logic [sombmc_pkg::DIST_W-1:0] LIMIT_MAX = '1;

   typedef struct packed {
      logic [1:0]  code;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [1:0]  elem;
      logic [15:0] weight;
      logic [7:0]  label;
      logic [15:0] q0, q1, q2, q3;
   } req_word_type;

   typedef struct packed {
      logic [7:0] label;
      logic [3:0] row;
      logic [3:0] col;
   } answer_type;

   logic clock;
   logic reset;

   sombmc_req_if req_bus();
   sombmc_rsp_if rsp_bus();
   sombmc_csr_if csr_bus();

   som_best_match_classifier_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // Mirror of the block state, updated as each word is accepted.
   logic signed [sombmc_pkg::WEIGHT_W-1:0] weight_mirror [sombmc_pkg::ELEM_COUNT];
   logic [sombmc_pkg::LABEL_W-1:0]         label_mirror [sombmc_pkg::NODE_COUNT];
   logic [sombmc_pkg::LABEL_W-1:0]         prev_label;
   logic [sombmc_pkg::DIST_W-1:0]          dist_limit;

   // Responses predicted for accepted queries, oldest first.
   answer_type pending_answers [$];

   // When set, neither the sender nor the receiver inserts idle cycles.
   bit quiet;
   int fail_count;
   int load_count;
   int query_count;
   int ignored_count;
   int answers_checked;
   int limit_writes;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs; far above the slowest legal run.
   initial begin
      #1_000_000;
      $display("*** FAILED ***");
      $display("Timeout with %0d responses still outstanding.", pending_answers.size());
      $finish;
   end

   // Finds the best-matching node for a query and the label of the labelled node
   // nearest to it on the grid. Updates the remembered label as the block does.
   function automatic answer_type classify_query(req_word_type w);
      longint     qv [4];
      longint     best;
      longint     node_dist;
      longint     d;
      int         r, c, e, n;
      int         wr, wc;
      int         grid, best_grid;
      bit         found;
      answer_type a;
      qv[0] = $signed(w.q0);
      qv[1] = $signed(w.q1);
      qv[2] = $signed(w.q2);
      qv[3] = $signed(w.q3);
      // The running minimum starts at the limit, so only strictly smaller
      // distances win, and the first node in row-major order keeps a tie.
      best = longint'(dist_limit);
      wr = 0;
      wc = 0;
      for (r = 0; r < sombmc_pkg::MAP_ROWS; r++) begin
         for (c = 0; c < sombmc_pkg::MAP_COLS; c++) begin
            n = r * sombmc_pkg::MAP_COLS + c;
            node_dist = 0;
            for (e = 0; e < sombmc_pkg::VECTOR_LEN; e++) begin
               d = qv[e] - longint'(weight_mirror[n * sombmc_pkg::VECTOR_LEN + e]);
               node_dist += d * d;
            end
            if (node_dist < best) begin
               best = node_dist;
               wr = r;
               wc = c;
            end
         end
      end
      // Without any labelled node the previous label is repeated.
      found = 1'b0;
      best_grid = 0;
      a.label = prev_label;
      for (r = 0; r < sombmc_pkg::MAP_ROWS; r++) begin
         for (c = 0; c < sombmc_pkg::MAP_COLS; c++) begin
            n = r * sombmc_pkg::MAP_COLS + c;
            if (label_mirror[n] != '0) begin
               grid = (r - wr) * (r - wr) + (c - wc) * (c - wc);
               if (!found || grid < best_grid) begin
                  found = 1'b1;
                  best_grid = grid;
                  a.label = label_mirror[n];
               end
            end
         end
      end
      prev_label = a.label;
      a.row = 4'(wr);
      a.col = 4'(wc);
      return a;
   endfunction

   // Applies one accepted word to the mirror and queues its response, if any.
   function automatic void apply_word(req_word_type w);
      bit in_map;
      in_map = (w.row < sombmc_pkg::MAP_ROWS) && (w.col < sombmc_pkg::MAP_COLS);
      case (w.code)
         sombmc_pkg::REQ_LOAD_WEIGHT: begin
            if (in_map && w.elem < sombmc_pkg::VECTOR_LEN) begin
               weight_mirror[(w.row * sombmc_pkg::MAP_COLS + w.col) * sombmc_pkg::VECTOR_LEN
                             + w.elem] = w.weight;
               load_count++;
            end else begin
               ignored_count++;
            end
         end
         sombmc_pkg::REQ_LOAD_LABEL: begin
            if (in_map) begin
               label_mirror[w.row * sombmc_pkg::MAP_COLS + w.col] = w.label;
               load_count++;
            end else begin
               ignored_count++;
            end
         end
         sombmc_pkg::REQ_QUERY: begin
            pending_answers.push_back(classify_query(w));
            query_count++;
         end
         default: ignored_count++;
      endcase
   endfunction

   // Fields that a word does not use still carry random values.
   function automatic req_word_type noise_word();
      req_word_type w;
      w.code   = 2'($urandom);
      w.row    = 4'($urandom);
      w.col    = 4'($urandom);
      w.elem   = 2'($urandom);
      w.weight = 16'($urandom);
      w.label  = 8'($urandom);
      w.q0     = 16'($urandom);
      w.q1     = 16'($urandom);
      w.q2     = 16'($urandom);
      w.q3     = 16'($urandom);
      return w;
   endfunction

   function automatic req_word_type weight_word(int r, int c, int e, logic [15:0] v);
      req_word_type w;
      w = noise_word();
      w.code   = sombmc_pkg::REQ_LOAD_WEIGHT;
      w.row    = 4'(r);
      w.col    = 4'(c);
      w.elem   = 2'(e);
      w.weight = v;
      return w;
   endfunction

   function automatic req_word_type label_word(int r, int c, logic [7:0] v);
      req_word_type w;
      w = noise_word();
      w.code  = sombmc_pkg::REQ_LOAD_LABEL;
      w.row   = 4'(r);
      w.col   = 4'(c);
      w.label = v;
      return w;
   endfunction

   function automatic req_word_type query_word(logic [15:0] a, logic [15:0] b,
                                               logic [15:0] c, logic [15:0] d);
      req_word_type w;
      w = noise_word();
      w.code = sombmc_pkg::REQ_QUERY;
      w.q0   = a;
      w.q1   = b;
      w.q2   = c;
      w.q3   = d;
      return w;
   endfunction

   // A query close to the weights of one node; a span of zero hits it exactly.
   function automatic req_word_type near_query(int node);
      logic [15:0] q [4];
      int          span;
      int          e;
      case ($urandom_range(0, 3))
         0:       span = 0;
         1:       span = 8;
         2:       span = 255;
         default: span = 4096;
      endcase
      for (e = 0; e < 4; e++) begin
         q[e] = weight_mirror[node * sombmc_pkg::VECTOR_LEN + e]
                + 16'(int'($urandom_range(0, 2 * span)) - span);
      end
      return query_word(q[0], q[1], q[2], q[3]);
   endfunction

   function automatic logic [15:0] random_weight();
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_word_type random_query();
      return query_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endfunction

   // Sends one word, possibly after a short idle burst, and waits for acceptance.
   task automatic send_word(input req_word_type w);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= w.code;
      req_bus.node_row     <= w.row;
      req_bus.node_col     <= w.col;
      req_bus.elem_index   <= w.elem;
      req_bus.weight_value <= w.weight;
      req_bus.label_value  <= w.label;
      req_bus.query_0      <= w.q0;
      req_bus.query_1      <= w.q1;
      req_bus.query_2      <= w.q2;
      req_bus.query_3      <= w.q3;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      apply_word(w);
   endtask

   // Stops sending and waits until every predicted response has been checked.
   task automatic wait_until_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the distance limit; callers make sure the block is idle first.
   task automatic write_limit(input logic [sombmc_pkg::DIST_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      dist_limit = value;
      limit_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Every weight and label is written before the first query reads the stores.
   // All labels start out as zero, so the map begins unlabelled.
   task automatic test_fill_map();
      int n, e;
      for (n = 0; n < sombmc_pkg::NODE_COUNT; n++) begin
         for (e = 0; e < sombmc_pkg::VECTOR_LEN; e++) begin
            send_word(weight_word(n / sombmc_pkg::MAP_COLS, n % sombmc_pkg::MAP_COLS, e,
                                  random_weight()));
         end
         send_word(label_word(n / sombmc_pkg::MAP_COLS, n % sombmc_pkg::MAP_COLS, 8'd0));
      end
   endtask

   // With no labelled node the block has to repeat its previous answer.
   task automatic test_unlabelled_map();
      int n;
      send_word(near_query($urandom_range(0, sombmc_pkg::NODE_COUNT - 1)));
      // One labelled node then answers for the whole map.
      send_word(label_word(0, 0, 8'h5A));
      send_word(near_query($urandom_range(0, sombmc_pkg::NODE_COUNT - 1)));
      // Clearing it again must bring back the label just returned.
      send_word(label_word(0, 0, 8'd0));
      send_word(random_query());
      // Sprinkle labels back so later queries see a varied grid.
      for (n = 0; n < 12; n++) begin
         send_word(label_word($urandom_range(0, sombmc_pkg::MAP_ROWS - 1),
                              $urandom_range(0, sombmc_pkg::MAP_COLS - 1),
                              8'($urandom_range(1, 255))));
      end
      send_word(near_query($urandom_range(0, sombmc_pkg::NODE_COUNT - 1)));
   endtask

   task automatic test_directed();
      req_word_type w;
      int e;
      // Full-scale positive weights and query: node (14,14) matches exactly.
      for (e = 0; e < sombmc_pkg::VECTOR_LEN; e++) send_word(weight_word(14, 14, e, 16'h7FFF));
      send_word(label_word(14, 14, 8'hFF));
      send_word(query_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      // Full-scale negative weights and query.
      for (e = 0; e < sombmc_pkg::VECTOR_LEN; e++) send_word(weight_word(7, 3, e, 16'h8000));
      send_word(query_word(16'h8000, 16'h8000, 16'h8000, 16'h8000));
      // A tie: node (3,9) gets the same weights as (14,14) and comes first.
      for (e = 0; e < sombmc_pkg::VECTOR_LEN; e++) send_word(weight_word(3, 9, e, 16'h7FFF));
      send_word(query_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      // Loads outside the map and the unused request code must change nothing.
      send_word(weight_word(15, 0, 0, 16'h0000));
      send_word(weight_word(3, 15, 1, 16'h0000));
      send_word(label_word(15, 15, 8'h01));
      w = noise_word();
      w.code = REQ_UNUSED;
      send_word(w);
      send_word(query_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_word(query_word(16'h0000, 16'h0000, 16'h0000, 16'h0000));
   endtask

   // Runs queries under the extreme limits and a few in between.
   task automatic test_limit_settings();
      logic [sombmc_pkg::DIST_W-1:0] limits [6];
      int i;
      limits[0] = '0;
      limits[1] = LIMIT_MAX;
      limits[2] = 36'd1;
      limits[3] = sombmc_pkg::DIST_W'({$urandom, $urandom});
      limits[4] = sombmc_pkg::DIST_W'($urandom_range(0, 1 << 20));
      limits[5] = sombmc_pkg::LIMIT_RESET;
      for (i = 0; i < 6; i++) begin
         wait_until_idle();
         write_limit(limits[i]);
         send_word(near_query($urandom_range(0, sombmc_pkg::NODE_COUNT - 1)));
         send_word(random_query());
      end
   endtask

   // Queries near stored nodes and random queries, mixed with loads, node copies and noise.
   task automatic test_random_traffic();
      req_word_type w;
      int chunk, i, e, pick, src, dst;
      for (chunk = 0; chunk < 2; chunk++) begin
         wait_until_idle();
         if (chunk == 0) begin
            write_limit(sombmc_pkg::DIST_W'($urandom_range(0, 1 << 30)));
         end else begin
            write_limit(sombmc_pkg::LIMIT_RESET);
         end
         // The last chunk runs without idling on either side.
         quiet = (chunk == 1);
         for (i = 0; i < 10; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               send_word(near_query($urandom_range(0, sombmc_pkg::NODE_COUNT - 1)));
            end else if (pick < 50) begin
               send_word(query_word(random_weight(), random_weight(), random_weight(),
                                    random_weight()));
            end else if (pick < 68) begin
               send_word(weight_word($urandom_range(0, sombmc_pkg::MAP_ROWS - 1),
                                     $urandom_range(0, sombmc_pkg::MAP_COLS - 1),
                                     $urandom_range(0, sombmc_pkg::VECTOR_LEN - 1),
                                     random_weight()));
            end else if (pick < 84) begin
               send_word(label_word($urandom_range(0, sombmc_pkg::MAP_ROWS - 1),
                                    $urandom_range(0, sombmc_pkg::MAP_COLS - 1),
                                    $urandom_range(0, 1) ? 8'($urandom) : 8'd0));
            end else if (pick < 92) begin
               // Copying one node onto another makes distance ties likely.
               src = $urandom_range(0, sombmc_pkg::NODE_COUNT - 1);
               dst = $urandom_range(0, sombmc_pkg::NODE_COUNT - 1);
               for (e = 0; e < sombmc_pkg::VECTOR_LEN; e++) begin
                  send_word(weight_word(dst / sombmc_pkg::MAP_COLS, dst % sombmc_pkg::MAP_COLS,
                                        e, weight_mirror[src * sombmc_pkg::VECTOR_LEN + e]));
               end
            end else begin
               w = noise_word();
               case ($urandom_range(0, 2))
                  0: begin
                     w.code = sombmc_pkg::REQ_LOAD_WEIGHT;
                     w.row  = 4'd15;
                  end
                  1: begin
                     w.code = sombmc_pkg::REQ_LOAD_LABEL;
                     w.col  = 4'd15;
                  end
                  default: w.code = REQ_UNUSED;
               endcase
               send_word(w);
            end
         end
      end
   endtask

   // The receiver stalls at random unless quiet is set.
   initial begin : rsp_stall_gen
      int stall_left;
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && !reset && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compares each accepted response with the oldest prediction.
   always @(posedge clock) begin : answer_check
      answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_answers.size() == 0) begin
            $error("Response with no query outstanding: label %0d, row %0d, col %0d",
                   rsp_bus.class_label, rsp_bus.winner_row, rsp_bus.winner_col);
            fail_count++;
         end else begin
            want = pending_answers.pop_front();
            answers_checked++;
            if (rsp_bus.class_label !== want.label) begin
               $error("class_label: expected %0d, actual %0d", want.label,
                      rsp_bus.class_label);
               fail_count++;
            end
            if (rsp_bus.winner_row !== want.row) begin
               $error("winner_row: expected %0d, actual %0d", want.row, rsp_bus.winner_row);
               fail_count++;
            end
            if (rsp_bus.winner_col !== want.col) begin
               $error("winner_col: expected %0d, actual %0d", want.col, rsp_bus.winner_col);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.req_type     = '0;
      req_bus.node_row     = '0;
      req_bus.node_col     = '0;
      req_bus.elem_index   = '0;
      req_bus.weight_value = '0;
      req_bus.label_value  = '0;
      req_bus.query_0      = '0;
      req_bus.query_1      = '0;
      req_bus.query_2      = '0;
      req_bus.query_3      = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.data         = '0;
      quiet                = 1'b0;
      prev_label           = '0;
      dist_limit           = sombmc_pkg::LIMIT_RESET;
      fail_count           = 0;
      load_count           = 0;
      query_count          = 0;
      ignored_count        = 0;
      answers_checked      = 0;
      limit_writes         = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_fill_map();
      test_unlabelled_map();
      wait_until_idle();
      test_directed();
      test_limit_settings();
      test_random_traffic();
      wait_until_idle();

      $display("Run covered %0d loads, %0d queries, %0d dropped words and %0d limit writes.",
               load_count, query_count, ignored_count, limit_writes);
      $display("%0d responses were checked across exact, near, tied and unlabelled cases.",
               answers_checked);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/sombmc_pkg.sv
design/sombmc_if.sv
design/sombmc_ram.sv
design/sombmc_dist_unit.sv
design/som_best_match_classifier_top.sv
dv/tb.sv
